/* rtl/mcpt_pkg.sv */
// Shared constants, function codes and lane control type for the matrix transform unit.
package mcpt_pkg;

  localparam int PORT_W        = 32;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int LANES          = 4;
  localparam int CM_ROWS        = 4;
  localparam int RB_ROWS        = 3;
  localparam int CM_AW          = $clog2(CM_ROWS);
  localparam int RB_AW          = $clog2(RB_ROWS);

  localparam logic [1:0] FUNC_IDENT = 2'd0;
  localparam logic [1:0] FUNC_ROW   = 2'd1;
  localparam logic [1:0] FUNC_POINT = 2'd2;

  typedef struct packed {
    logic mul_en;
    logic shift3;
    logic acc_load;
    logic acc_add;
    logic sum_load;
  } lane_ctrl_t;

endpackage

/* rtl/mcpt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module mcpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mcpt_lanes.sv */
// Four multiply lanes with accumulators and the shift-and-saturate finish.
module mcpt_lanes import mcpt_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  lane_ctrl_t                    ctrl,
  input  logic [LANES*ELEM_WIDTH-1:0]   op_a,
  input  logic [LANES*ELEM_WIDTH-1:0]   op_b,
  output logic [LANES*ELEM_WIDTH-1:0]   res,
  output logic [LANES-1:0]              sat
);

  localparam int W      = ELEM_WIDTH;
  localparam int PROD_W = (2 * W > W + FRAC_BITS) ? 2 * W : W + FRAC_BITS;
  localparam int ACC_W  = PROD_W + 2;

  logic signed [2*W-1:0]    mul  [LANES];
  logic signed [PROD_W-1:0] prod [LANES];
  logic signed [ACC_W-1:0]  acc  [LANES];
  logic signed [ACC_W-1:0]  sh   [LANES];
  logic [ACC_W-W:0]         hi   [LANES];
  logic signed [ACC_W-1:0]  psum;

  always_comb begin
    psum = '0;
    for (int l = 0; l < LANES; l++) begin
      mul[l] = $signed(op_a[l*W +: W]) * $signed(op_b[l*W +: W]);
      psum   = psum + ACC_W'(prod[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      for (int l = 0; l < LANES; l++) begin
        // homogeneous w of a point is one, so the last column is just shifted in
        if (ctrl.shift3 && (l == LANES - 1)) begin
          prod[l] <= PROD_W'($signed(op_a[l*W +: W])) <<< FRAC_BITS;
        end else begin
          prod[l] <= PROD_W'(mul[l]);
        end
      end
    end
    if (ctrl.sum_load) begin
      acc[0] <= psum;
    end else if (ctrl.acc_load) begin
      for (int l = 0; l < LANES; l++) begin
        acc[l] <= ACC_W'(prod[l]);
      end
    end else if (ctrl.acc_add) begin
      for (int l = 0; l < LANES; l++) begin
        acc[l] <= acc[l] + ACC_W'(prod[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sh[l] = acc[l] >>> FRAC_BITS;
      hi[l] = sh[l][ACC_W-1:W-1];
      sat[l] = !((&hi[l]) || !(|hi[l]));
      if (!sat[l]) begin
        res[l*W +: W] = sh[l][W-1:0];
      end else if (acc[l][ACC_W-1]) begin
        res[l*W +: W] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res[l*W +: W] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

endmodule

/* rtl/matrix_compose_point_transform_unit.sv */
// Top level: sequencer around the matrix memory, row buffer memory and multiply lanes.
//
// A point (func 2) passes from the accepting edge through the matrix read and the
// product, sum and output registers to the one-cycle done beat, and the next item
// is accepted in the done cycle: three rows are read from the matrix memory one per
// cycle and pass through the multiply, sum and saturate stages. A row item (func 1)
// and an identity request (func 0) never raise busy, except the fourth row, which
// composes the matrix while busy: for each of the four result rows, one matrix
// memory read and four row beats through the four multipliers, then a write back.
// The receiver cannot stall, so out_x, out_y, out_z and clipped are valid only
// while done is high. No clearing pass is needed after reset: rows of the matrix
// memory carry valid bits and read as identity until rewritten.
module matrix_compose_point_transform_unit import mcpt_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic signed [PORT_W-1:0] elem_a,
  input  logic signed [PORT_W-1:0] elem_b,
  input  logic signed [PORT_W-1:0] elem_c,
  input  logic signed [PORT_W-1:0] elem_d,
  output logic                     done,
  output logic signed [PORT_W-1:0] out_x,
  output logic signed [PORT_W-1:0] out_y,
  output logic signed [PORT_W-1:0] out_z,
  output logic                     clipped
);

  localparam int W     = ELEM_WIDTH;
  localparam int ROW_W = LANES * W;

  localparam logic signed [63:0] ONE_FULL = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] MAX_POS  = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic [W-1:0]       ONE_Q    = (ONE_FULL > MAX_POS) ? MAX_POS[W-1:0]
                                                                 : ONE_FULL[W-1:0];

  localparam logic [2:0] PT_FIRST = 3'd1;
  localparam logic [2:0] PT_X     = 3'd3;
  localparam logic [2:0] PT_Y     = 3'd4;
  localparam logic [2:0] PT_Z     = 3'd5;
  localparam logic [2:0] MX_CROW  = 3'd1;
  localparam logic [2:0] MX_MUL0  = 3'd2;
  localparam logic [2:0] MX_LOAD  = 3'd3;
  localparam logic [2:0] MX_MUL3  = 3'd5;
  localparam logic [2:0] MX_ADDL  = 3'd6;
  localparam logic [2:0] MX_WB    = 3'd7;
  localparam logic [CM_AW-1:0] LAST_ROW = CM_AW'(CM_ROWS - 1);
  localparam logic [CM_AW-1:0] RB_FULL  = CM_AW'(RB_ROWS);

  typedef enum logic [1:0] {S_IDLE, S_PT, S_MX} state_t;

  state_t            state;
  logic              accept;
  logic [CM_AW-1:0]  row_count;
  logic [CM_ROWS-1:0] row_valid;
  logic              rd_valid;
  logic [CM_AW-1:0]  rd_addr;
  logic [2:0]        cnt;
  logic [2:0]        t;
  logic [CM_AW-1:0]  ri;
  logic [1:0]        k;
  logic              clip_acc;

  logic [ROW_W-1:0]  in_row;
  logic [ROW_W-1:0]  pt;
  logic [ROW_W-1:0]  rlast;
  logic [ROW_W-1:0]  creg;
  logic [ROW_W-1:0]  ident;
  logic [ROW_W-1:0]  cm_row;
  logic [ROW_W-1:0]  cm_rdata;
  logic [ROW_W-1:0]  rb_rdata;
  logic [ROW_W-1:0]  op_a;
  logic [ROW_W-1:0]  op_b;
  logic [ROW_W-1:0]  res;
  logic [LANES-1:0]  sat;
  logic [CM_AW-1:0]  cm_raddr;
  logic [RB_AW-1:0]  rb_raddr;
  logic              cm_we;
  logic              rb_we;
  lane_ctrl_t        lctrl;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_row = {elem_d[W-1:0], elem_c[W-1:0], elem_b[W-1:0], elem_a[W-1:0]};

  assign cm_raddr = (state == S_PT) ? cnt[CM_AW-1:0] :
                    (state == S_MX) ? ri : '0;
  assign rb_raddr = RB_AW'(t[1:0] - 2'd1);
  assign k        = t[1:0] - 2'd2;
  assign cm_we    = (state == S_MX) && (t == MX_WB);
  assign rb_we    = accept && (func == FUNC_ROW) && (row_count != RB_FULL);

  // rows never written since the last identity request read as identity
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ident[l*W +: W] = (CM_AW'(l) == rd_addr) ? ONE_Q : '0;
    end
  end
  assign cm_row = rd_valid ? cm_rdata : ident;

  always_comb begin
    lctrl = '0;
    op_a  = cm_row;
    op_b  = pt;
    case (state)
      S_PT: begin
        lctrl.mul_en   = (cnt <= PT_X);
        lctrl.shift3   = 1'b1;
        lctrl.sum_load = (cnt >= MX_MUL0) && (cnt <= PT_Y);
      end
      S_MX: begin
        for (int l = 0; l < LANES; l++) begin
          op_a[l*W +: W] = creg[k*W +: W];
        end
        op_b           = (t == MX_MUL3) ? rlast : rb_rdata;
        lctrl.mul_en   = (t >= MX_MUL0) && (t <= MX_MUL3);
        lctrl.acc_load = (t == MX_LOAD);
        lctrl.acc_add  = (t > MX_LOAD) && (t <= MX_ADDL);
      end
      default: begin
        lctrl = '0;
      end
    endcase
  end

  mcpt_ram #(.WIDTH(ROW_W), .DEPTH(CM_ROWS)) u_cm_ram (
    .clk   (clk),
    .we    (cm_we),
    .waddr (ri),
    .wdata (res),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  mcpt_ram #(.WIDTH(ROW_W), .DEPTH(RB_ROWS)) u_rb_ram (
    .clk   (clk),
    .we    (rb_we),
    .waddr (row_count[RB_AW-1:0]),
    .wdata (in_row),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  mcpt_lanes #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lanes (
    .clk  (clk),
    .ctrl (lctrl),
    .op_a (op_a),
    .op_b (op_b),
    .res  (res),
    .sat  (sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      row_valid <= '0;
      done      <= 1'b0;
      cnt       <= '0;
      t         <= '0;
      ri        <= '0;
    end else begin
      done <= (state == S_PT) && (cnt == PT_Z);
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              FUNC_IDENT: begin
                row_valid <= '0;
                row_count <= '0;
              end
              FUNC_ROW: begin
                if (row_count == RB_FULL) begin
                  state     <= S_MX;
                  ri        <= '0;
                  t         <= '0;
                  row_count <= '0;
                end else begin
                  row_count <= row_count + 1'b1;
                end
              end
              FUNC_POINT: begin
                state <= S_PT;
                cnt   <= PT_FIRST;
              end
              default: begin
              end
            endcase
          end
        end
        S_PT: begin
          cnt <= cnt + 1'b1;
          if (cnt == PT_Z) begin
            state <= S_IDLE;
          end
        end
        S_MX: begin
          t <= t + 1'b1;
          if (t == MX_WB) begin
            row_valid[ri] <= 1'b1;
            if (ri == LAST_ROW) begin
              state <= S_IDLE;
            end else begin
              ri <= ri + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end

    // payload, no reset
    rd_valid <= row_valid[cm_raddr];
    rd_addr  <= cm_raddr;
    if (accept && (func == FUNC_POINT)) begin
      pt <= {{W{1'b0}}, in_row[3*W-1:0]};
    end
    if (accept && (func == FUNC_ROW)) begin
      rlast <= in_row;
    end
    if ((state == S_MX) && (t == MX_CROW)) begin
      creg <= cm_row;
    end
    if (state == S_PT) begin
      if (cnt == PT_X) begin
        out_x    <= PORT_W'($signed(res[W-1:0]));
        clip_acc <= sat[0];
      end
      if (cnt == PT_Y) begin
        out_y    <= PORT_W'($signed(res[W-1:0]));
        clip_acc <= clip_acc | sat[0];
      end
      if (cnt == PT_Z) begin
        out_z   <= PORT_W'($signed(res[W-1:0]));
        clipped <= clip_acc | sat[0];
      end
    end
  end

endmodule

/* rtl/mcpt_checker.sv */
// Port-level checks on the transform unit's command handshake and done beat, with bind.
module mcpt_checker import mcpt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] func,
  input logic       done
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy after reset");

  a_point_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_POINT)) |=> busy)
    else $error("point beat did not raise busy");

  a_ident_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == FUNC_IDENT)) |=> !busy)
    else $error("identity request raised busy");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (func == FUNC_POINT), 6))
    else $error("done without a point beat six cycles before");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

endmodule

bind matrix_compose_point_transform_unit mcpt_checker u_mcpt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);

/* tb/tb_top.sv */
// Testbench for the matrix compose and point transform unit: directed and random beats.
module tb_top;
  import mcpt_pkg::*;

  typedef logic signed [PORT_W-1:0] elem_t;

  typedef struct {
    logic [1:0] op;
    elem_t      a;
    elem_t      b;
    elem_t      c;
    elem_t      d;
  } xform_cmd_t;

  typedef struct {
    elem_t x;
    elem_t y;
    elem_t z;
    logic  clip;
  } point_res_t;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam elem_t Q_MAX = 32'sh7fff_ffff;
  localparam elem_t Q_MIN = 32'sh8000_0000;
  localparam elem_t ONE_Q = 32'sh0001_0000;
  localparam elem_t TWO_Q = 32'sh0002_0000;
  localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
  localparam logic signed [67:0] SAT_LO = -68'sd2147483648;
  localparam int RANDOM_ITEMS = 850;

  logic  clk = 1'b0;
  logic  rst;
  logic  start;
  logic  busy;
  logic  [1:0] func;
  elem_t elem_a, elem_b, elem_c, elem_d;
  logic  done;
  elem_t out_x, out_y, out_z;
  logic  clipped;

  // predictor state
  elem_t cur_mat [16];
  elem_t row_hold [12];
  int    rows_held;

  point_res_t pending_points [$];
  point_res_t want;

  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_clipped = 0;
  int  n_composed = 0;
  bit  no_idle = 1'b0;

  matrix_compose_point_transform_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .func    (func),
    .elem_a  (elem_a),
    .elem_b  (elem_b),
    .elem_c  (elem_c),
    .elem_d  (elem_d),
    .done    (done),
    .out_x   (out_x),
    .out_y   (out_y),
    .out_z   (out_z),
    .clipped (clipped)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // exact four-term dot product, floor-shifted back to Q16.16 but not yet clamped
  function automatic logic signed [67:0] dot4_q(input elem_t p0, q0, p1, q1,
                                                 p2, q2, p3, q3);
    logic signed [67:0] w [8];
    logic signed [67:0] acc;
    w[0] = p0; w[1] = q0; w[2] = p1; w[3] = q1;
    w[4] = p2; w[5] = q2; w[6] = p3; w[7] = q3;
    acc = w[0] * w[1] + w[2] * w[3] + w[4] * w[5] + w[6] * w[7];
    return acc >>> FRAC_BITS_DEF;
  endfunction

  function automatic bit out_of_range(input logic signed [67:0] v);
    return (v > SAT_HI) || (v < SAT_LO);
  endfunction

  function automatic elem_t clamp_q(input logic signed [67:0] v);
    if (v > SAT_HI) return Q_MAX;
    if (v < SAT_LO) return Q_MIN;
    return v[31:0];
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 16; i++) cur_mat[i] = (i % 5 == 0) ? ONE_Q : '0;
  endtask

  task automatic predict_transform(input xform_cmd_t cmd);
    elem_t rhs [16];
    elem_t nxt [16];
    logic signed [67:0] s [3];
    point_res_t r;
    case (cmd.op)
      FUNC_IDENT: begin
        load_identity();
        rows_held = 0;
      end
      FUNC_ROW: begin
        if (rows_held < 3) begin
          row_hold[rows_held*4]   = cmd.a;
          row_hold[rows_held*4+1] = cmd.b;
          row_hold[rows_held*4+2] = cmd.c;
          row_hold[rows_held*4+3] = cmd.d;
          rows_held++;
        end else begin
          for (int j = 0; j < 12; j++) rhs[j] = row_hold[j];
          rhs[12] = cmd.a; rhs[13] = cmd.b; rhs[14] = cmd.c; rhs[15] = cmd.d;
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
              nxt[i*4+j] = clamp_q(dot4_q(cur_mat[i*4], rhs[j], cur_mat[i*4+1], rhs[4+j],
                                          cur_mat[i*4+2], rhs[8+j],
                                          cur_mat[i*4+3], rhs[12+j]));
          cur_mat = nxt;
          rows_held = 0;
          n_composed++;
        end
      end
      FUNC_POINT: begin
        for (int i = 0; i < 3; i++)
          s[i] = dot4_q(cur_mat[i*4], cmd.a, cur_mat[i*4+1], cmd.b,
                        cur_mat[i*4+2], cmd.c, cur_mat[i*4+3], ONE_Q);
        r.x = clamp_q(s[0]);
        r.y = clamp_q(s[1]);
        r.z = clamp_q(s[2]);
        r.clip = out_of_range(s[0]) | out_of_range(s[1]) | out_of_range(s[2]);
        pending_points.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // start stays high after acceptance; the next call either lowers it or drives a new beat
  task automatic send_cmd(input logic [1:0] op, input elem_t a, b, c, d);
    int gap;
    xform_cmd_t cmd;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func   <= op;
    elem_a <= a;
    elem_b <= b;
    elem_c <= c;
    elem_d <= d;
    start  <= 1'b1;
    cmd.op = op; cmd.a = a; cmd.b = b; cmd.c = c; cmd.d = d;
    do @(posedge clk); while (busy);
    predict_transform(cmd);
    n_sent++;
  endtask

  task automatic settle_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input elem_t exp_v, got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, got %h %h %h %b",
                 $time, out_x, out_y, out_z, clipped);
      end else begin
        want = pending_points.pop_front();
        check_field("out_x", want.x, out_x);
        check_field("out_y", want.y, out_y);
        check_field("out_z", want.z, out_z);
        check_field("clipped", elem_t'(want.clip), elem_t'(clipped));
        n_checked++;
        if (want.clip) n_clipped++;
      end
    end
  end

  function automatic elem_t rand_q(input int sel);
    case (sel)
      0: return int'($urandom_range(0, 196608)) - 98304;      // about +-1.5
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 6))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return ONE_Q;
          4: return -ONE_Q;
          5: return -1;
          default: return 1;
        endcase
      end
      default: return int'($urandom_range(0, 33554432)) - 16777216;  // about +-256
    endcase
  endfunction

  function automatic int pick_row_sel();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return 0;
    if (r < 17) return 3;
    if (r < 18) return 1;
    return 2;
  endfunction

  function automatic int pick_point_sel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 3;
    if (r < 9) return 1;
    return 2;
  endfunction

  task automatic test_identity_points();
    send_cmd(FUNC_IDENT, '0, '0, '0, '0);
    send_cmd(FUNC_POINT, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
    send_cmd(FUNC_POINT, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
    send_cmd(FUNC_POINT, '0, '0, '0, -1);
    send_cmd(FUNC_POINT, 1, -1, ONE_Q, '0);
  endtask

  // translation pushes coordinates past full scale; includes a full drain
  task automatic test_translation_clip();
    send_cmd(FUNC_ROW, ONE_Q, '0, '0, Q_MAX);
    send_cmd(FUNC_ROW, '0, ONE_Q, '0, Q_MIN);
    send_cmd(FUNC_ROW, '0, '0, ONE_Q, ONE_Q);
    send_cmd(FUNC_ROW, '0, '0, '0, ONE_Q);
    send_cmd(FUNC_POINT, Q_MAX, Q_MIN, '0, '0);
    send_cmd(FUNC_POINT, '0, '0, '0, '0);
    settle_results();
  endtask

  // identity mid-sequence restarts the row count; unused selector leaves it alone
  task automatic test_row_sequence_breaks();
    send_cmd(FUNC_ROW, $urandom, $urandom, $urandom, $urandom);
    send_cmd(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
    send_cmd(FUNC_IDENT, '0, '0, '0, '0);
    send_cmd(FUNC_ROW, TWO_Q, '0, '0, '0);
    send_cmd(FUNC_ROW, '0, TWO_Q, '0, '0);
    send_cmd(FUNC_UNUSED, Q_MIN, Q_MAX, -1, ONE_Q);
    send_cmd(FUNC_ROW, '0, '0, TWO_Q, '0);
    send_cmd(FUNC_ROW, '0, '0, '0, ONE_Q);
    send_cmd(FUNC_POINT, 32'sh4000_0000, 32'shc000_0000, 3, '0);
  endtask

  // composition that saturates silently, then a point through the clamped matrix
  task automatic test_compose_saturation();
    send_cmd(FUNC_ROW, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_cmd(FUNC_ROW, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_cmd(FUNC_ROW, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_cmd(FUNC_ROW, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_cmd(FUNC_POINT, 1, -1, Q_MIN, '0);
  endtask

  task automatic send_random_matrix();
    if ($urandom_range(0, 1)) send_cmd(FUNC_IDENT, $urandom, $urandom, $urandom, $urandom);
    for (int r = 0; r < 4; r++) begin
      if ($urandom_range(0, 19) == 0)
        send_cmd(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 29) == 0)
        send_cmd(FUNC_IDENT, '0, '0, '0, '0);
      send_cmd(FUNC_ROW, rand_q(pick_row_sel()), rand_q(pick_row_sel()),
               rand_q(pick_row_sel()), rand_q(pick_row_sel()));
    end
  endtask

  task automatic test_random_traffic();
    int base;
    int pick;
    int npts;
    base = n_sent;
    while (n_sent - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 49) == 0) settle_results();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_cmd(FUNC_IDENT, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 40) begin
        send_random_matrix();
      end else if (pick < 85) begin
        npts = $urandom_range(1, 6);
        repeat (npts)
          send_cmd(FUNC_POINT, rand_q(pick_point_sel()), rand_q(pick_point_sel()),
                   rand_q(pick_point_sel()), $urandom);
      end else begin
        send_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_IDENT;
    elem_a = '0;
    elem_b = '0;
    elem_c = '0;
    elem_d = '0;
    load_identity();
    rows_held = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_identity_points();
    test_translation_clip();
    test_row_sequence_breaks();
    test_compose_saturation();
    test_random_traffic();

    settle_results();
    repeat (64) @(posedge clk);
    $display("summary: %0d beats sent, %0d matrices composed", n_sent, n_composed);
    $display("summary: %0d points checked, %0d of them clipped", n_checked, n_clipped);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
rtl/mcpt_pkg.sv
rtl/mcpt_ram.sv
rtl/mcpt_lanes.sv
rtl/matrix_compose_point_transform_unit.sv
rtl/mcpt_checker.sv
tb/tb_top.sv
